// File: hdl/kss_pkg.sv
// Shared types, constants and the scan code lookup table for the keyboard
// scan stack interface. No dependencies.
package kss_pkg;

  localparam int DEFAULT_STACK_DEPTH = 7;

  typedef enum logic [1:0] {
    OP_KEY         = 2'd0,
    OP_READ_DATA   = 2'd1,
    OP_READ_STATUS = 2'd2,
    OP_COMMAND     = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] key_char;
    logic [7:0] command_byte;
  } item_t;

  localparam logic [6:0] CHAR_DEL       = 7'd127;
  localparam logic [6:0] CHAR_ESC       = 7'd27;
  localparam logic [6:0] CHAR_LOWER_A   = 7'd97;
  localparam logic [6:0] CHAR_LOWER_Z   = 7'd122;
  localparam logic [6:0] CASE_OFFSET    = 7'd32;
  localparam logic [6:0] CODE_BACKSPACE = 7'd114;
  localparam logic [6:0] CODE_ESCAPE    = 7'd118;
  localparam logic [6:0] CODE_UNKNOWN   = 7'd127;

  localparam logic [7:0] OVERRUN_FLAG   = 8'h20;
  localparam logic [2:0] CMD_CLASS      = 3'b110;
  localparam logic [1:0] CMD_CLEAR_BITS = 2'b11;
  localparam logic [7:0] CMD_BUZZ_OFF   = 8'hD0;
  localparam logic [7:0] CMD_BUZZ_ON    = 8'hDC;

  typedef logic [6:0] code_tbl_t [0:127];

  // Key matrix table: entry i holds the character found at matrix position i.
  localparam logic [7:0] KEY_TABLE [0:127] = '{
    8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h23, 8'hB2,
    8'hFF, 8'hB1, 8'hBD, 8'h41, 8'hFF, 8'hB3, 8'hFF, 8'hB4,
    8'hFF, 8'hFF, 8'h2D, 8'hBA, 8'hFF, 8'h51, 8'h2E, 8'h2C,
    8'h4D, 8'h4C, 8'h4B, 8'h4A, 8'h4F, 8'h49, 8'h55, 8'h2F,
    8'h20, 8'hB9, 8'hFF, 8'hBE, 8'h4E, 8'h56, 8'h58, 8'h5A,
    8'h48, 8'h47, 8'h53, 8'h50, 8'h59, 8'h54, 8'h52, 8'h57,
    8'hFF, 8'h40, 8'hBC, 8'hBB, 8'hFF, 8'hB8, 8'hB7, 8'hB6,
    8'h3C, 8'h2A, 8'h25, 8'hFF, 8'hB5, 8'hFF, 8'hB0, 8'hFF,
    8'h3B, 8'h29, 8'h3A, 8'h22, 8'h21, 8'hFF, 8'h23, 8'hB2,
    8'hFF, 8'hB1, 8'hBD, 8'hFF, 8'hFF, 8'hB3, 8'hFF, 8'hB4,
    8'hFF, 8'hFF, 8'h20, 8'hBA, 8'hFF, 8'h2B, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30,
    8'h20, 8'hB9, 8'hFF, 8'hBE, 8'h28, 8'h3D, 8'h3F, 8'hFF,
    8'h27, 8'h5E, 8'h3E, 8'h26, 8'h20, 8'h5C, 8'h20, 8'h20,
    8'hFF, 8'h23, 8'hBC, 8'hBB, 8'hFF, 8'hB8, 8'hB7, 8'hB6,
    8'h2E, 8'h24, 8'h2C, 8'hFF, 8'hB5, 8'hFF, 8'hB0, 8'hFF
  };

  // Inverse of the key table, built at elaboration: character -> scan code.
  // Later matrix positions win; the last position takes no part.
  function automatic code_tbl_t build_scan_table();
    code_tbl_t t;
    for (int c = 0; c < 128; c++) begin
      t[c] = CODE_UNKNOWN;
    end
    for (int i = 0; i < 127; i++) begin
      if (KEY_TABLE[i][7] == 1'b0) begin
        t[KEY_TABLE[i][6:0]] = 7'(127 - i);
      end
    end
    return t;
  endfunction

  localparam code_tbl_t SCAN_TABLE = build_scan_table();

endpackage

// File: hdl/kss_scan.sv
// Character to scan code conversion: upper-casing, special keys, table lookup.
// Depends on kss_pkg.
module kss_scan (
  input  logic [6:0] key_char,
  output logic [6:0] scan_code
);

  logic [6:0] upper;

  always_comb begin
    upper = key_char;
    if (key_char >= kss_pkg::CHAR_LOWER_A && key_char <= kss_pkg::CHAR_LOWER_Z) begin
      upper = key_char - kss_pkg::CASE_OFFSET;
    end
    if (upper == kss_pkg::CHAR_DEL) begin
      scan_code = kss_pkg::CODE_BACKSPACE;
    end else if (upper == kss_pkg::CHAR_ESC) begin
      scan_code = kss_pkg::CODE_ESCAPE;
    end else begin
      scan_code = kss_pkg::SCAN_TABLE[upper];
    end
  end

endmodule

// File: hdl/kss_core.sv
// Execute stage: code stack memory, count, status, buzzer and result register.
// Depends on kss_pkg.
module kss_core #(
  parameter int STACK_DEPTH = kss_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  kss_pkg::item_t  item,
  input  logic [6:0]      scan_code,
  output logic            slot_free,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      read_data,
  output logic            key_interrupt,
  output logic            buzzer_level
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

  logic [6:0]       stack_mem [0:STACK_DEPTH-1];
  logic [CNT_W-1:0] held_count, held_count_next, count_dec;
  logic [7:0]       status_byte, status_byte_next;
  logic             buzzer_state, buzzer_state_next;
  logic             exec, push, pop, irq_next;
  logic [7:0]       rd_next;
  logic [7:0]       rd_q;
  logic [6:0]       pop_q;
  logic             pop_sel;

  assign slot_free = !out_valid || !out_stall;
  assign exec      = item_valid && slot_free;
  assign count_dec = held_count - 1'b1;

  always_comb begin
    held_count_next   = held_count;
    status_byte_next  = status_byte;
    buzzer_state_next = buzzer_state;
    push              = 1'b0;
    pop               = 1'b0;
    irq_next          = 1'b0;
    rd_next           = 8'd0;
    case (item.op)
      kss_pkg::OP_KEY: begin
        if (held_count < FULL_COUNT) begin
          push             = 1'b1;
          irq_next         = 1'b1;
          held_count_next  = held_count + 1'b1;
          status_byte_next = 8'(held_count_next);
        end else begin
          status_byte_next = status_byte | kss_pkg::OVERRUN_FLAG;
        end
      end
      kss_pkg::OP_READ_DATA: begin
        if (held_count != '0) begin
          pop              = 1'b1;
          held_count_next  = count_dec;
          status_byte_next = 8'(count_dec);
        end
      end
      kss_pkg::OP_READ_STATUS: begin
        rd_next = status_byte;
      end
      kss_pkg::OP_COMMAND: begin
        if (item.command_byte[7:5] == kss_pkg::CMD_CLASS) begin
          if ((item.command_byte[1:0] & kss_pkg::CMD_CLEAR_BITS) != 2'b00) begin
            held_count_next  = '0;
            status_byte_next = 8'd0;
          end else if (item.command_byte == kss_pkg::CMD_BUZZ_OFF) begin
            buzzer_state_next = 1'b0;
          end else if (item.command_byte == kss_pkg::CMD_BUZZ_ON) begin
            buzzer_state_next = 1'b1;
          end
        end
      end
      default: begin
        rd_next = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= '0;
      status_byte  <= 8'd0;
      buzzer_state <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid <= item_valid;
      end
      if (exec) begin
        held_count   <= held_count_next;
        status_byte  <= status_byte_next;
        buzzer_state <= buzzer_state_next;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (exec) begin
      rd_q          <= rd_next;
      pop_sel       <= pop;
      key_interrupt <= irq_next;
    end
  end

  // Stack memory: one write (push) or one registered read (pop) per transaction
  always_ff @(posedge clk) begin
    if (exec && push) begin
      stack_mem[held_count[IDX_W-1:0]] <= scan_code;
    end
    if (exec && pop) begin
      pop_q <= stack_mem[count_dec[IDX_W-1:0]];
    end
  end

  assign read_data    = pop_sel ? {1'b0, pop_q} : rd_q;
  assign buzzer_level = buzzer_state;

`ifndef SYNTH
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    held_count <= FULL_COUNT)
    else $error("held count beyond stack depth");

  a_irq_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_interrupt |-> status_byte == 8'(held_count))
    else $error("status does not track count after push");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    exec && item.op == kss_pkg::OP_READ_DATA && held_count != '0
    |=> held_count == $past(count_dec))
    else $error("pop did not decrement count");

  a_overrun: assert property (@(posedge clk) disable iff (rst)
    exec && item.op == kss_pkg::OP_KEY && held_count == FULL_COUNT
    |=> status_byte[5] && held_count == $past(held_count))
    else $error("overrun not flagged or count changed");
`endif

endmodule

// File: hdl/keyboard_scan_stack_interface_unit.sv
// Top level of the keyboard scan stack interface: input register, scan code
// conversion, execute stage. Depends on kss_pkg, kss_scan, kss_core.
//
//   channel | signals                              | direction
//   in      | in_valid, in_stall, op, key_char,    | item in
//           | command_byte                         |
//   out     | out_valid, out_stall, read_data,     | result out
//           | key_interrupt, buzzer_level          |
//
// One transaction per cycle sustained while out_stall is low; an item that is taken
// passes the input register, then execute into the result register, and out_stall
// can hold it between the two. Push and pop each touch the stack once.
// rst is synchronous: count, status and buzzer clear; stack contents do not.
// out_stall holds the result and backs up into in_stall within the same cycle.
module keyboard_scan_stack_interface_unit #(
  parameter int STACK_DEPTH = kss_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [6:0] key_char,
  input  logic [7:0] command_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       key_interrupt,
  output logic       buzzer_level
);

  logic           s1_valid;
  kss_pkg::item_t s1_item;
  logic           slot_free;
  logic [6:0]     scan_code;

  assign in_stall = s1_valid && !slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.op           <= kss_pkg::op_t'(op);
      s1_item.key_char     <= key_char;
      s1_item.command_byte <= command_byte;
    end
  end

  kss_scan u_scan (
    .key_char  (s1_item.key_char),
    .scan_code (scan_code)
  );

  kss_core #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (s1_valid),
    .item          (s1_item),
    .scan_code     (scan_code),
    .slot_free     (slot_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .key_interrupt (key_interrupt),
    .buzzer_level  (buzzer_level)
  );

endmodule
